>>> sv/vrc2a_pkg.sv
`default_nettype none
package vrc2a_pkg;

  localparam int REG_COUNT   = 19;
  localparam int LATCH_COUNT = 8;
  localparam int REG_AW      = $clog2(REG_COUNT);
  localparam int LATCH_AW    = $clog2(LATCH_COUNT);
  localparam int BANK_CNT_W  = 9;

  // command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_RESET = 2'd2;

  // effect codes
  localparam logic [2:0] EFF_PRG    = 3'd0;
  localparam logic [2:0] EFF_CHR    = 3'd1;
  localparam logic [2:0] EFF_MIRROR = 3'd2;
  localparam logic [2:0] EFF_READ   = 3'd3;
  localparam logic [2:0] EFF_NONE   = 3'd4;

  // register file slots
  localparam logic [REG_AW-1:0] REG_PRG0     = REG_AW'(0);
  localparam logic [REG_AW-1:0] REG_MIRROR   = REG_AW'(1);
  localparam logic [REG_AW-1:0] REG_PRG1     = REG_AW'(2);
  localparam logic [REG_AW-1:0] REG_CHR_BASE = REG_AW'(3);

  // address decode
  localparam logic [3:0] PAGE_PRG0    = 4'h8;
  localparam logic [3:0] PAGE_MIRROR  = 4'h9;
  localparam logic [3:0] PAGE_PRG1    = 4'hA;
  localparam logic [3:0] PAGE_CHR_LO  = 4'hB;
  localparam logic [3:0] PAGE_CHR_HI  = 4'hE;

  localparam logic [7:0] READ_MISS = 8'hA1;

  typedef struct packed {
    logic [1:0]          cmd;
    logic                hit;
    logic [REG_AW-1:0]   reg_idx;
    logic [LATCH_AW-1:0] latch_idx;
    logic                nib_hi;
    logic [7:0]          data;
  } item_t;

  typedef struct packed {
    logic [2:0] effect;
    logic [2:0] slot;
    logic [7:0] value;
    logic       last;
  } result_t;

  typedef struct packed {
    logic       reg_we;
    logic       lat_we;
    logic [7:0] lat_data;
  } wb_t;

endpackage
`default_nettype wire

>>> sv/vrc2a_bank_mapper_unit.sv
`default_nettype none
// Channel  Dir  Bits        Contents
// s_axis   in   tuser[1:0]  command
//               tdata[23:0] address, write_data
// m_axis   out  tuser[2:0]  effect
//               tdata[15:0] slot, value, zero fill; tlast = last
// cfg      in   9           prg_bank_count
//
// One beat is taken per cycle while the output accepts; a reset command gives
// two output beats and holds the input until its second beat is taken. Each
// input beat reads the synchronous RAMs into the execute stage register s1,
// and its result then goes to the output register. Register file and CHR
// latches live in RAMs with per-entry valid bits that rst clears at once, so there is no clearing pass.
// Backpressure on m_axis stalls the execute stage and then s_axis.
module vrc2a_bank_mapper_unit
  import vrc2a_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [23:0]           s_axis_tdata,   // address, write_data
  input  wire logic [1:0]            s_axis_tuser,   // command
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic      [15:0]           m_axis_tdata,   // slot, value, zero fill
  output logic      [2:0]            m_axis_tuser,   // effect
  output logic                       m_axis_tlast,
  input  wire logic                  cfg_wr_en,
  input  wire logic [BANK_CNT_W-1:0] cfg_wr_data
);

  logic [BANK_CNT_W-1:0] bank_count;

  item_t   dec;
  item_t   s1;
  logic    s1_valid;
  logic    phase;
  result_t res;
  result_t out_res;
  wb_t     wb;

  logic s_fire;
  logic out_free;
  logic s1_take;
  logic s1_done;
  logic reg_we;
  logic lat_we;

  logic [7:0]             reg_rdata;
  logic [7:0]             lat_rdata;
  logic [REG_COUNT-1:0]   reg_vld;
  logic [LATCH_COUNT-1:0] lat_vld;

  logic       s1_reg_fwd;
  logic [7:0] s1_reg_fwd_data;
  logic       s1_reg_vld;
  logic       s1_lat_fwd;
  logic [7:0] s1_lat_fwd_data;
  logic       s1_lat_vld;
  logic [7:0] reg_data;
  logic [7:0] lat_data;

  vrc2a_decode u_decode (
    .command    (s_axis_tuser),
    .address    (s_axis_tdata[15:0]),
    .write_data (s_axis_tdata[23:16]),
    .item       (dec)
  );

  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s1_take       = s1_valid && out_free;
  assign s1_done       = s1_take && res.last;
  assign s_axis_tready = !s1_valid || s1_done;
  assign reg_we        = s1_take && wb.reg_we;
  assign lat_we        = s1_take && wb.lat_we;

  vrc2a_ram #(.WIDTH(8), .DEPTH(REG_COUNT)) u_reg_ram (
    .clk   (clk),
    .we    (reg_we),
    .waddr (s1.reg_idx),
    .wdata (s1.data),
    .re    (s_fire),
    .raddr (dec.reg_idx),
    .rdata (reg_rdata)
  );

  vrc2a_ram #(.WIDTH(8), .DEPTH(LATCH_COUNT)) u_lat_ram (
    .clk   (clk),
    .we    (lat_we),
    .waddr (s1.latch_idx),
    .wdata (wb.lat_data),
    .re    (s_fire),
    .raddr (dec.latch_idx),
    .rdata (lat_rdata)
  );

  // forwarded write wins, then RAM word if ever written, else reset value
  assign reg_data = s1_reg_fwd ? s1_reg_fwd_data : (s1_reg_vld ? reg_rdata : 8'd0);
  assign lat_data = s1_lat_fwd ? s1_lat_fwd_data : (s1_lat_vld ? lat_rdata : 8'd0);

  vrc2a_exec u_exec (
    .item       (s1),
    .phase      (phase),
    .reg_data   (reg_data),
    .lat_data   (lat_data),
    .bank_count (bank_count),
    .res        (res),
    .wb         (wb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_count    <= BANK_CNT_W'(16);
      s1_valid      <= 1'b0;
      phase         <= 1'b0;
      m_axis_tvalid <= 1'b0;
      reg_vld       <= '0;
      lat_vld       <= '0;
    end else begin
      if (cfg_wr_en) begin
        bank_count <= cfg_wr_data;
      end
      if (s_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_done) begin
        s1_valid <= 1'b0;
      end
      if (s1_take) begin
        phase <= !res.last;
      end
      if (s1_take) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (reg_we) begin
        reg_vld[s1.reg_idx] <= 1'b1;
      end
      if (lat_we) begin
        lat_vld[s1.latch_idx] <= 1'b1;
      end
    end
  end

  // capture the item with its bypass state at the edge of its RAM read
  always_ff @(posedge clk) begin
    if (s_fire) begin
      s1              <= dec;
      s1_reg_fwd      <= reg_we && (s1.reg_idx == dec.reg_idx);
      s1_reg_fwd_data <= s1.data;
      s1_reg_vld      <= reg_vld[dec.reg_idx];
      s1_lat_fwd      <= lat_we && (s1.latch_idx == dec.latch_idx);
      s1_lat_fwd_data <= wb.lat_data;
      s1_lat_vld      <= lat_vld[dec.latch_idx];
    end
    if (s1_take) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {5'd0, out_res.value, out_res.slot};
  assign m_axis_tuser = out_res.effect;
  assign m_axis_tlast = out_res.last;

  a_reset_holds_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1.cmd == CMD_RESET && !phase) |-> !s_axis_tready)
    else $error("input taken while first reset beat pending");

  a_phase_owner: assert property (@(posedge clk) disable iff (rst)
    phase |-> (s1_valid && s1.cmd == CMD_RESET))
    else $error("second beat phase without a reset item");

  a_latch_implies_reg: assert property (@(posedge clk) disable iff (rst)
    lat_we |-> reg_we)
    else $error("latch written without register file write");

  a_second_beat_follows: assert property (@(posedge clk) disable iff (rst)
    (s1_take && !res.last) |=> (s1_valid && phase))
    else $error("reset item dropped before its last beat");

endmodule
`default_nettype wire

>>> sv/vrc2a_ram.sv
`default_nettype none
module vrc2a_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word when the same entry is written in that cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> sv/vrc2a_decode.sv
`default_nettype none
module vrc2a_decode
  import vrc2a_pkg::*;
(
  input  wire logic [1:0]  command,
  input  wire logic [15:0] address,
  input  wire logic [7:0]  write_data,
  output item_t            item
);

  logic [3:0] page;
  logic [1:0] off;
  logic [1:0] pair;
  logic       low_ok;

  always_comb begin
    page   = address[15:12];
    off    = address[1:0];
    low_ok = (address[11:2] == 10'd0);
    pair   = 2'(page - PAGE_CHR_LO);

    item.cmd       = command;
    item.data      = write_data;
    item.hit       = 1'b0;
    item.reg_idx   = REG_PRG0;
    item.latch_idx = {pair, off[0]};
    item.nib_hi    = off[1];

    if (low_ok) begin
      if (page == PAGE_PRG0) begin
        item.hit     = 1'b1;
        item.reg_idx = REG_PRG0;
      end else if (page == PAGE_MIRROR) begin
        item.hit     = 1'b1;
        item.reg_idx = REG_MIRROR;
      end else if (page == PAGE_PRG1) begin
        item.hit     = 1'b1;
        item.reg_idx = REG_PRG1;
      end else if (page >= PAGE_CHR_LO && page <= PAGE_CHR_HI) begin
        item.hit     = 1'b1;
        item.reg_idx = REG_CHR_BASE + REG_AW'({pair, off});
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/vrc2a_exec.sv
`default_nettype none
module vrc2a_exec
  import vrc2a_pkg::*;
(
  input  wire item_t                 item,
  input  wire logic                  phase,
  input  wire logic [7:0]            reg_data,
  input  wire logic [7:0]            lat_data,
  input  wire logic [BANK_CNT_W-1:0] bank_count,
  output result_t                    res,
  output wb_t                        wb
);

  logic [7:0] lat_new;

  always_comb begin
    // offset bit 1 picks the nibble
    lat_new = item.nib_hi ? {item.data[3:0], lat_data[3:0]}
                          : {lat_data[7:4], item.data[3:0]};

    res.effect  = EFF_NONE;
    res.slot    = 3'd0;
    res.value   = 8'd0;
    res.last    = 1'b1;
    wb.reg_we   = 1'b0;
    wb.lat_we   = 1'b0;
    wb.lat_data = lat_new;

    unique case (item.cmd)
      CMD_RESET: begin
        // map the two upper slots to the last two banks
        res.effect = EFF_PRG;
        res.slot   = {2'b01, phase};
        res.value  = bank_count[7:0] - 8'd2 + {7'd0, phase};
        res.last   = phase;
      end
      CMD_READ: begin
        res.effect = EFF_READ;
        res.value  = item.hit ? reg_data : READ_MISS;
      end
      CMD_WRITE: begin
        if (item.hit) begin
          wb.reg_we = 1'b1;
          unique case (item.reg_idx)
            REG_PRG0: begin
              res.effect = EFF_PRG;
              res.value  = {4'd0, item.data[3:0]};
            end
            REG_PRG1: begin
              res.effect = EFF_PRG;
              res.slot   = 3'd1;
              res.value  = {4'd0, item.data[3:0]};
            end
            REG_MIRROR: begin
              res.effect = EFF_MIRROR;
              res.value  = {6'd0, item.data[1:0]};
            end
            default: begin
              wb.lat_we  = 1'b1;
              res.effect = EFF_CHR;
              res.slot   = item.latch_idx;
              res.value  = {1'b0, lat_new[7:1]};
            end
          endcase
        end
      end
      default: begin
        res.effect = EFF_NONE;
      end
    endcase
  end

endmodule
`default_nettype wire
